### rtl/core/tksg_pkg.sv
// shared types and constants for the trivium keystream generator
package tksg_pkg;

    localparam int STATE_BITS = 288;
    localparam int KEY_BITS   = 80;
    localparam int IV_BASE    = 93;
    localparam int WORD_BITS  = 64;
    localparam int COUNT_W    = 7;
    localparam int IDX_W      = 6;
    localparam int ROUNDS_W   = 12;
    localparam int CFG_IDX_W  = 3;

    localparam logic [ROUNDS_W-1:0] WARMUP_RESET = 12'd576;

    // opcodes of an input word
    localparam logic OP_RESTART  = 1'b0;
    localparam logic OP_GENERATE = 1'b1;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_KEY_LOW  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_KEY_HIGH = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_IV_LOW   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_IV_HIGH  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_WARMUP   = 3'd4;

    // controller to datapath commands
    typedef struct packed {
        logic               load;
        logic               step;
        logic               capture;
        logic               clear_word;
        logic               publish;
        logic [IDX_W-1:0]   bit_idx;
        logic [COUNT_W-1:0] pub_count;
    } t_cmd;

    // datapath to controller status
    typedef struct packed {
        logic [ROUNDS_W-1:0] warmup_rounds;
    } t_status;

endpackage

### rtl/core/tksg_dp.sv
// datapath: configuration registers, 288-bit cipher state and result registers
module tksg_dp (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_cfg_we,
    input  logic [tksg_pkg::CFG_IDX_W-1:0]       i_cfg_index,
    input  logic [tksg_pkg::WORD_BITS-1:0]       i_cfg_data,
    input  tksg_pkg::t_cmd                       i_cmd,
    output tksg_pkg::t_status                    o_status,
    output logic [tksg_pkg::WORD_BITS-1:0]       o_keystream_word,
    output logic [tksg_pkg::COUNT_W-1:0]         o_bit_count
);

    logic [63:0]                         r_key_low;
    logic [15:0]                         r_key_high;
    logic [63:0]                         r_iv_low;
    logic [15:0]                         r_iv_high;
    logic [tksg_pkg::ROUNDS_W-1:0]       r_warmup;
    logic [tksg_pkg::STATE_BITS-1:0]     r_state;
    logic [tksg_pkg::STATE_BITS-1:0]     n_state;
    logic [tksg_pkg::STATE_BITS-1:0]     load_state;
    logic [tksg_pkg::WORD_BITS-1:0]      r_word;
    logic [tksg_pkg::WORD_BITS-1:0]      r_out_word;
    logic [tksg_pkg::COUNT_W-1:0]        r_out_count;
    logic                                t_a;
    logic                                t_b;
    logic                                t_c;
    logic                                z_bit;

    // one round of the update
    always_comb begin
        t_a   = r_state[65] ^ r_state[92];
        t_b   = r_state[161] ^ r_state[176];
        t_c   = r_state[242] ^ r_state[287];
        z_bit = t_a ^ t_b ^ t_c;
        n_state      = {r_state[tksg_pkg::STATE_BITS-2:0], 1'b0};
        n_state[0]   = t_c ^ (r_state[285] & r_state[286]) ^ r_state[68];
        n_state[93]  = t_a ^ (r_state[90] & r_state[91]) ^ r_state[170];
        n_state[177] = t_b ^ (r_state[174] & r_state[175]) ^ r_state[263];
    end

    // key at the bottom, iv above, top three bits set
    always_comb begin
        load_state = '0;
        load_state[tksg_pkg::KEY_BITS-1:0] = {r_key_high, r_key_low};
        load_state[tksg_pkg::IV_BASE +: tksg_pkg::KEY_BITS] = {r_iv_high, r_iv_low};
        load_state[287:285] = 3'b111;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_key_low  <= '0;
            r_key_high <= '0;
            r_iv_low   <= '0;
            r_iv_high  <= '0;
            r_warmup   <= tksg_pkg::WARMUP_RESET;
            r_state    <= '0;
        end else begin
            if (i_cfg_we) begin
                unique case (i_cfg_index)
                    tksg_pkg::CFG_KEY_LOW:  r_key_low  <= i_cfg_data;
                    tksg_pkg::CFG_KEY_HIGH: r_key_high <= i_cfg_data[15:0];
                    tksg_pkg::CFG_IV_LOW:   r_iv_low   <= i_cfg_data;
                    tksg_pkg::CFG_IV_HIGH:  r_iv_high  <= i_cfg_data[15:0];
                    tksg_pkg::CFG_WARMUP:   r_warmup   <= i_cfg_data[tksg_pkg::ROUNDS_W-1:0];
                    default: ;
                endcase
            end
            if (i_cmd.load) begin
                r_state <= load_state;
            end else if (i_cmd.step) begin
                r_state <= n_state;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.clear_word) begin
            r_word <= '0;
        end else if (i_cmd.step && i_cmd.capture) begin
            r_word[i_cmd.bit_idx] <= z_bit;
        end
        if (i_cmd.publish) begin
            r_out_word  <= r_word;
            r_out_count <= i_cmd.pub_count;
        end
    end

    assign o_status.warmup_rounds = r_warmup;
    assign o_keystream_word       = r_out_word;
    assign o_bit_count            = r_out_count;

endmodule

### rtl/core/tksg_ctrl.sv
// controller: sequences load, warm-up and generate rounds and the output handshake
module tksg_ctrl #(
    parameter int MAX_BITS_PER_ITEM = 64
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_in_valid,
    output logic                             o_in_ready,
    input  logic                             i_opcode,
    input  logic [tksg_pkg::COUNT_W-1:0]     i_bits_wanted,
    output logic                             o_out_valid,
    input  logic                             i_out_ready,
    input  tksg_pkg::t_status                i_status,
    output tksg_pkg::t_cmd                   o_cmd
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_RUN,
        S_DONE
    } t_state;

    localparam logic [tksg_pkg::COUNT_W-1:0] MAX_WANT =
        tksg_pkg::COUNT_W'(MAX_BITS_PER_ITEM);

    t_state                          r_state;
    t_state                          n_state;
    logic [tksg_pkg::ROUNDS_W-1:0]   r_count;
    logic [tksg_pkg::ROUNDS_W-1:0]   n_count;
    logic [tksg_pkg::IDX_W-1:0]      r_idx;
    logic [tksg_pkg::IDX_W-1:0]      n_idx;
    logic                            r_gen;
    logic                            n_gen;
    logic [tksg_pkg::COUNT_W-1:0]    r_nbits;
    logic [tksg_pkg::COUNT_W-1:0]    n_nbits;
    logic                            r_out_valid;
    logic                            n_out_valid;
    logic                            accept;
    logic                            slot_free;
    logic [tksg_pkg::COUNT_W-1:0]    want;

    assign accept    = i_in_valid && (r_state == S_IDLE);
    assign slot_free = !r_out_valid || i_out_ready;
    assign want      = (i_bits_wanted > MAX_WANT) ? MAX_WANT : i_bits_wanted;

    always_comb begin
        n_state     = r_state;
        n_count     = r_count;
        n_idx       = r_idx;
        n_gen       = r_gen;
        n_nbits     = r_nbits;
        n_out_valid = r_out_valid && !i_out_ready;
        o_cmd       = '0;
        o_cmd.bit_idx   = r_idx;
        o_cmd.capture   = r_gen;
        o_cmd.pub_count = r_nbits;
        unique case (r_state)
            S_IDLE: begin
                if (accept) begin
                    o_cmd.clear_word = 1'b1;
                    o_cmd.load       = (i_opcode == tksg_pkg::OP_RESTART);
                    n_idx            = '0;
                    n_gen            = (i_opcode == tksg_pkg::OP_GENERATE);
                    if (i_opcode == tksg_pkg::OP_RESTART) begin
                        n_count = i_status.warmup_rounds;
                        n_nbits = '0;
                    end else begin
                        n_count = tksg_pkg::ROUNDS_W'(want);
                        n_nbits = want;
                    end
                    n_state = S_RUN;
                end
            end
            S_RUN: begin
                if (r_count != '0) begin
                    o_cmd.step = 1'b1;
                    n_count    = r_count - 1'b1;
                    n_idx      = r_idx + 1'b1;
                end else begin
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                if (slot_free) begin
                    o_cmd.publish = 1'b1;
                    n_out_valid   = 1'b1;
                    n_state       = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_idx       <= '0;
            r_gen       <= 1'b0;
            r_nbits     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_idx       <= n_idx;
            r_gen       <= n_gen;
            r_nbits     <= n_nbits;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;

endmodule

### rtl/core/trivium_keystream_generator_top.sv
// top level of the trivium keystream generator
//
// channel   direction  handshake                  payload
// input     in         i_in_valid / o_in_ready    i_opcode, i_bits_wanted
// output    out        o_out_valid / i_out_ready  o_keystream_word, o_bit_count
// config    in         i_cfg_we (no wait)         i_cfg_index, i_cfg_data
//
// one state round per cycle in the shared round unit of the datapath
// restart word: load on acceptance, then warmup_rounds rounds, then an empty word is published
// generate word: min(bits_wanted, MAX_BITS_PER_ITEM) rounds, then the word is published
// one word at a time; the next word is taken while a result waits in the output register
// synchronous active-low reset: state all zero, warm-up count 576, key and iv zero
// a stalled output holds the finished word; the sequencer waits only if the slot is full
module trivium_keystream_generator_top #(
    parameter int MAX_BITS_PER_ITEM = 64
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    // input words
    input  logic                               i_in_valid,
    output logic                               o_in_ready,
    input  logic                               i_opcode,
    input  logic [tksg_pkg::COUNT_W-1:0]       i_bits_wanted,
    // result words
    output logic                               o_out_valid,
    input  logic                               i_out_ready,
    output logic [tksg_pkg::WORD_BITS-1:0]     o_keystream_word,
    output logic [tksg_pkg::COUNT_W-1:0]       o_bit_count,
    // register writes
    input  logic                               i_cfg_we,
    input  logic [tksg_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [tksg_pkg::WORD_BITS-1:0]     i_cfg_data
);

    // command and status between sequencer and datapath
    tksg_pkg::t_cmd    cmd;
    tksg_pkg::t_status status;

    // sequencer: round counter, bit index, output slot
    tksg_ctrl #(
        .MAX_BITS_PER_ITEM (MAX_BITS_PER_ITEM)
    ) u_ctrl (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_in_valid),
        .o_in_ready    (o_in_ready),
        .i_opcode      (i_opcode),
        .i_bits_wanted (i_bits_wanted),
        .o_out_valid   (o_out_valid),
        .i_out_ready   (i_out_ready),
        .i_status      (status),
        .o_cmd         (cmd)
    );

    // datapath: registers, cipher state, keystream collection
    tksg_dp u_dp (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cfg_we         (i_cfg_we),
        .i_cfg_index      (i_cfg_index),
        .i_cfg_data       (i_cfg_data),
        .i_cmd            (cmd),
        .o_status         (status),
        .o_keystream_word (o_keystream_word),
        .o_bit_count      (o_bit_count)
    );

endmodule

### sim/keystream_checker.sv
// checker for the trivium keystream generator: watches the channels, predicts and compares
module keystream_checker #(
    parameter int MAX_BITS = 64
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_in_valid,
    input  logic                               i_in_ready,
    input  logic                               i_opcode,
    input  logic [tksg_pkg::COUNT_W-1:0]       i_bits_wanted,
    input  logic                               i_out_valid,
    input  logic                               i_out_ready,
    input  logic [tksg_pkg::WORD_BITS-1:0]     i_keystream_word,
    input  logic [tksg_pkg::COUNT_W-1:0]       i_bit_count,
    input  logic                               i_cfg_we,
    input  logic [tksg_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [tksg_pkg::WORD_BITS-1:0]     i_cfg_data,
    output int unsigned                        o_fail_count,
    output int unsigned                        o_outstanding
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic [tksg_pkg::WORD_BITS-1:0] keystream;
        logic [tksg_pkg::COUNT_W-1:0]   count;
    } t_ks_word;

    // predicted cipher state and register copies
    logic [tksg_pkg::STATE_BITS-1:0] cipher_bits = '0;
    logic [63:0]                     key_lo      = '0;
    logic [15:0]                     key_hi      = '0;
    logic [63:0]                     iv_lo       = '0;
    logic [15:0]                     iv_hi       = '0;
    logic [tksg_pkg::ROUNDS_W-1:0]   warmup      = tksg_pkg::WARMUP_RESET;

    t_ks_word    expected_words[$];
    t_ks_word    oldest;
    int unsigned fail_total = 0;

    assign o_fail_count = fail_total;

    // one trivium round, returns the keystream bit
    function automatic logic clock_state();
        logic t1, t2, t3, z;
        t1 = cipher_bits[65] ^ cipher_bits[92];
        t2 = cipher_bits[161] ^ cipher_bits[176];
        t3 = cipher_bits[242] ^ cipher_bits[287];
        z  = t1 ^ t2 ^ t3;
        t1 = t1 ^ (cipher_bits[90] & cipher_bits[91]) ^ cipher_bits[170];
        t2 = t2 ^ (cipher_bits[174] & cipher_bits[175]) ^ cipher_bits[263];
        t3 = t3 ^ (cipher_bits[285] & cipher_bits[286]) ^ cipher_bits[68];
        cipher_bits      = {cipher_bits[tksg_pkg::STATE_BITS-2:0], t3};
        cipher_bits[93]  = t1;
        cipher_bits[177] = t2;
        return z;
    endfunction

    function automatic void load_and_warm();
        cipher_bits = '0;
        cipher_bits[tksg_pkg::KEY_BITS-1:0]                  = {key_hi, key_lo};
        cipher_bits[tksg_pkg::IV_BASE +: tksg_pkg::KEY_BITS] = {iv_hi, iv_lo};
        cipher_bits[287:285]                                 = 3'b111;
        for (int r = 0; r < int'(warmup); r++) begin
            void'(clock_state());
        end
    endfunction

    function automatic t_ks_word keystream_for(input logic [tksg_pkg::COUNT_W-1:0] want);
        t_ks_word w;
        int       n;
        w = '0;
        n = (int'(want) > MAX_BITS) ? MAX_BITS : int'(want);
        for (int i = 0; i < n; i++) begin
            w.keystream[i] = clock_state();
        end
        w.count = tksg_pkg::COUNT_W'(n);
        return w;
    endfunction

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            cipher_bits = '0;
            key_lo      = '0;
            key_hi      = '0;
            iv_lo       = '0;
            iv_hi       = '0;
            warmup      = tksg_pkg::WARMUP_RESET;
            expected_words.delete();
            o_outstanding <= 0;
        end else begin
            if (i_out_valid && i_out_ready) begin
                if (expected_words.size() == 0) begin
                    fail_total++;
                    $display("%0t: unexpected word: expected none, actual %h / %0d",
                             $time, i_keystream_word, i_bit_count);
                end else begin
                    oldest = expected_words.pop_front();
                    if (i_keystream_word !== oldest.keystream) begin
                        fail_total++;
                        $display("%0t: keystream_word mismatch: expected %h, actual %h",
                                 $time, oldest.keystream, i_keystream_word);
                    end
                    if (i_bit_count !== oldest.count) begin
                        fail_total++;
                        $display("%0t: bit_count mismatch: expected %0d, actual %0d",
                                 $time, oldest.count, i_bit_count);
                    end
                end
            end
            if (i_cfg_we) begin
                case (i_cfg_index)
                    tksg_pkg::CFG_KEY_LOW:  key_lo = i_cfg_data;
                    tksg_pkg::CFG_KEY_HIGH: key_hi = i_cfg_data[15:0];
                    tksg_pkg::CFG_IV_LOW:   iv_lo  = i_cfg_data;
                    tksg_pkg::CFG_IV_HIGH:  iv_hi  = i_cfg_data[15:0];
                    tksg_pkg::CFG_WARMUP:   warmup = i_cfg_data[tksg_pkg::ROUNDS_W-1:0];
                    default: ;
                endcase
            end
            if (i_in_valid && i_in_ready) begin
                if (i_opcode == tksg_pkg::OP_RESTART) begin
                    load_and_warm();
                    expected_words.push_back('0);
                end else begin
                    expected_words.push_back(keystream_for(i_bits_wanted));
                end
            end
            o_outstanding <= expected_words.size();
        end
    end

endmodule

### sim/tb_trivium_keystream_generator_top.sv
// testbench top for the trivium keystream generator: stimulus, idling and verdict
module tb_trivium_keystream_generator_top;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int MAX_BITS     = 64;
    localparam int RANDOM_WORDS = 1600;

    // register indexes the block does not decode
    localparam logic [tksg_pkg::CFG_IDX_W-1:0] CFG_UNUSED_FIRST = 3'd5;
    localparam logic [tksg_pkg::CFG_IDX_W-1:0] CFG_UNUSED_LAST  = 3'd7;

    logic                           i_clk         = 1'b0;
    logic                           rst_n         = 1'b0;
    logic                           in_valid      = 1'b0;
    logic                           in_ready;
    logic                           in_opcode     = tksg_pkg::OP_GENERATE;
    logic [tksg_pkg::COUNT_W-1:0]   in_bits       = '0;
    logic                           out_valid;
    logic                           out_ready     = 1'b0;
    logic [tksg_pkg::WORD_BITS-1:0] ks_word;
    logic [tksg_pkg::COUNT_W-1:0]   ks_count;
    logic                           cfg_we        = 1'b0;
    logic [tksg_pkg::CFG_IDX_W-1:0] cfg_index     = tksg_pkg::CFG_KEY_LOW;
    logic [tksg_pkg::WORD_BITS-1:0] cfg_data      = '0;

    int unsigned fail_count;
    int unsigned outstanding;

    // idling rates in percent, changed per phase
    int unsigned send_idle_pct = 18;
    int unsigned recv_idle_pct = 87;
    int unsigned words_sent    = 0;

    always #5 i_clk = ~i_clk;

    trivium_keystream_generator_top #(
        .MAX_BITS_PER_ITEM (MAX_BITS)
    ) i_dut (
        .i_clk            (i_clk),
        .i_rst_n          (rst_n),
        .i_in_valid       (in_valid),
        .o_in_ready       (in_ready),
        .i_opcode         (in_opcode),
        .i_bits_wanted    (in_bits),
        .o_out_valid      (out_valid),
        .i_out_ready      (out_ready),
        .o_keystream_word (ks_word),
        .o_bit_count      (ks_count),
        .i_cfg_we         (cfg_we),
        .i_cfg_index      (cfg_index),
        .i_cfg_data       (cfg_data)
    );

    keystream_checker #(
        .MAX_BITS (MAX_BITS)
    ) i_checker (
        .i_clk            (i_clk),
        .i_rst_n          (rst_n),
        .i_in_valid       (in_valid),
        .i_in_ready       (in_ready),
        .i_opcode         (in_opcode),
        .i_bits_wanted    (in_bits),
        .i_out_valid      (out_valid),
        .i_out_ready      (out_ready),
        .i_keystream_word (ks_word),
        .i_bit_count      (ks_count),
        .i_cfg_we         (cfg_we),
        .i_cfg_index      (cfg_index),
        .i_cfg_data       (cfg_data),
        .o_fail_count     (fail_count),
        .o_outstanding    (outstanding)
    );

    // receiver: one fresh ready decision per edge
    always @(posedge i_clk) begin
        out_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
    end

    // register write, only ever issued while the block is idle
    task automatic write_reg(input logic [tksg_pkg::CFG_IDX_W-1:0] idx,
                             input logic [tksg_pkg::WORD_BITS-1:0] data);
        @(posedge i_clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge i_clk);
        cfg_we    <= 1'b0;
    endtask

    // present one word and hold it until taken; entered and left just after an edge
    task automatic send_word(input logic op, input logic [tksg_pkg::COUNT_W-1:0] bits);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            in_valid <= 1'b0;
            @(posedge i_clk);
        end
        in_valid  <= 1'b1;
        in_opcode <= op;
        in_bits   <= bits;
        do @(posedge i_clk); while (!in_ready);
        words_sent++;
    endtask

    // sender holds off until every predicted word has come back
    task automatic wait_idle();
        in_valid <= 1'b0;
        @(posedge i_clk);
        while (outstanding != 0) @(posedge i_clk);
        repeat (6) @(posedge i_clk);
    endtask

    // mostly ordinary lengths, with zero and over-range requests mixed in
    function automatic logic [tksg_pkg::COUNT_W-1:0] pick_length();
        int unsigned roll;
        roll = $urandom_range(0, 99);
        if (roll < 5)
            return '0;
        else if (roll < 13)
            return tksg_pkg::COUNT_W'($urandom_range(65, 127));
        else if (roll < 23)
            return tksg_pkg::COUNT_W'(MAX_BITS);
        else
            return tksg_pkg::COUNT_W'($urandom_range(1, 63));
    endfunction

    // short warm-ups keep the run quick; the long ones still turn up
    function automatic logic [tksg_pkg::WORD_BITS-1:0] pick_warmup();
        int unsigned roll;
        roll = $urandom_range(0, 99);
        if (roll < 60)
            return tksg_pkg::WORD_BITS'($urandom_range(0, 40));
        else if (roll < 80)
            return tksg_pkg::WORD_BITS'($urandom_range(41, 600));
        else if (roll < 93)
            return tksg_pkg::WORD_BITS'(tksg_pkg::WARMUP_RESET);
        else if (roll < 98)
            return tksg_pkg::WORD_BITS'(1152);
        else
            return {$urandom, $urandom};
    endfunction

    function automatic logic [tksg_pkg::WORD_BITS-1:0] pick_data();
        int unsigned roll;
        roll = $urandom_range(0, 9);
        if (roll == 0)
            return '0;
        else if (roll == 1)
            return '1;
        else
            return {$urandom, $urandom};
    endfunction

    // one keying: new register values at random, a restart, then a run of mostly generate words
    task automatic run_session(input int unsigned gen_words);
        wait_idle();
        if ($urandom_range(0, 9) < 7) write_reg(tksg_pkg::CFG_KEY_LOW, pick_data());
        if ($urandom_range(0, 9) < 7) write_reg(tksg_pkg::CFG_KEY_HIGH, pick_data());
        if ($urandom_range(0, 9) < 7) write_reg(tksg_pkg::CFG_IV_LOW, pick_data());
        if ($urandom_range(0, 9) < 7) write_reg(tksg_pkg::CFG_IV_HIGH, pick_data());
        if ($urandom_range(0, 9) < 6) write_reg(tksg_pkg::CFG_WARMUP, pick_warmup());
        if ($urandom_range(0, 9) < 2)
            write_reg(tksg_pkg::CFG_IDX_W'($urandom_range(CFG_UNUSED_FIRST, CFG_UNUSED_LAST)),
                      pick_data());
        send_word(tksg_pkg::OP_RESTART, tksg_pkg::COUNT_W'($urandom));
        repeat (gen_words) begin
            // occasional restart in the middle of a run
            if ($urandom_range(0, 99) < 4)
                send_word(tksg_pkg::OP_RESTART, tksg_pkg::COUNT_W'($urandom));
            else
                send_word(tksg_pkg::OP_GENERATE, pick_length());
        end
    endtask

    initial begin
        repeat (4) @(posedge i_clk);
        rst_n <= 1'b1;

        // keystream before any restart must stay all zero, zero length included
        send_word(tksg_pkg::OP_GENERATE, tksg_pkg::COUNT_W'(MAX_BITS));
        send_word(tksg_pkg::OP_GENERATE, '0);
        send_word(tksg_pkg::OP_GENERATE, 7'd1);

        // all-ones key, zero iv, no warm-up; junk in the unused indexes
        wait_idle();
        write_reg(tksg_pkg::CFG_KEY_LOW, '1);
        write_reg(tksg_pkg::CFG_KEY_HIGH, '1);
        write_reg(tksg_pkg::CFG_IV_LOW, '0);
        write_reg(tksg_pkg::CFG_IV_HIGH, '0);
        write_reg(tksg_pkg::CFG_WARMUP, '0);
        write_reg(CFG_UNUSED_FIRST, '1);
        write_reg(CFG_UNUSED_LAST, {$urandom, $urandom});
        send_word(tksg_pkg::OP_RESTART, '1);
        send_word(tksg_pkg::OP_GENERATE, tksg_pkg::COUNT_W'(MAX_BITS));
        send_word(tksg_pkg::OP_GENERATE, 7'd127);
        send_word(tksg_pkg::OP_GENERATE, 7'd65);
        send_word(tksg_pkg::OP_GENERATE, '0);
        send_word(tksg_pkg::OP_GENERATE, 7'd1);
        send_word(tksg_pkg::OP_GENERATE, tksg_pkg::COUNT_W'(MAX_BITS));

        // zero key, all-ones iv, longest warm-up (upper data bits must be dropped)
        wait_idle();
        write_reg(tksg_pkg::CFG_KEY_LOW, '0);
        write_reg(tksg_pkg::CFG_KEY_HIGH, '0);
        write_reg(tksg_pkg::CFG_IV_LOW, '1);
        write_reg(tksg_pkg::CFG_IV_HIGH, '1);
        write_reg(tksg_pkg::CFG_WARMUP, '1);
        send_word(tksg_pkg::OP_RESTART, '0);
        send_word(tksg_pkg::OP_GENERATE, tksg_pkg::COUNT_W'(MAX_BITS));
        send_word(tksg_pkg::OP_GENERATE, 7'd100);

        // random key and iv with the reset warm-up count, restart twice
        wait_idle();
        write_reg(tksg_pkg::CFG_KEY_LOW, {$urandom, $urandom});
        write_reg(tksg_pkg::CFG_KEY_HIGH, {$urandom, $urandom});
        write_reg(tksg_pkg::CFG_IV_LOW, {$urandom, $urandom});
        write_reg(tksg_pkg::CFG_IV_HIGH, {$urandom, $urandom});
        write_reg(tksg_pkg::CFG_WARMUP, tksg_pkg::WORD_BITS'(tksg_pkg::WARMUP_RESET));
        send_word(tksg_pkg::OP_RESTART, '0);
        send_word(tksg_pkg::OP_GENERATE, tksg_pkg::COUNT_W'(MAX_BITS));
        send_word(tksg_pkg::OP_GENERATE, 7'd33);
        send_word(tksg_pkg::OP_RESTART, '0);
        send_word(tksg_pkg::OP_GENERATE, tksg_pkg::COUNT_W'(MAX_BITS));

        // random part in three idling phases: slow receiver, slow sender, no idling
        words_sent = 0;
        for (int phase = 0; phase < 3; phase++) begin
            wait_idle();
            case (phase)
                0: begin
                    send_idle_pct = 18;
                    recv_idle_pct = 87;
                end
                1: begin
                    send_idle_pct = 87;
                    recv_idle_pct = 18;
                end
                default: begin
                    send_idle_pct = 0;
                    recv_idle_pct = 0;
                end
            endcase
            while (words_sent < (phase + 1) * RANDOM_WORDS / 3)
                run_session($urandom_range(4, 24));
        end

        // drain, then leave room for any stray word
        wait_idle();
        repeat (100) @(posedge i_clk);
        if (fail_count == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

    // watchdog well beyond the slowest correct run
    initial begin
        #30_000_000;
        $display("CHECKS FAILED");
        $finish;
    end

endmodule
